>>> hdl/address_symbol_range_lookup_core_assert.svh
// Assertion helpers for the lookup core.
// Each macro takes a label, an antecedent and a consequent, and samples on
// the rising edge of clock with reset as the disable condition.
`ifndef ADDRESS_SYMBOL_RANGE_LOOKUP_CORE_ASSERT_SVH
`define ADDRESS_SYMBOL_RANGE_LOOKUP_CORE_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define ASRL_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("address_symbol_range_lookup_core: assertion failed");

// Consequent holds in the cycle after the antecedent.
`define ASRL_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("address_symbol_range_lookup_core: assertion failed");

`endif

>>> hdl/asrl_pkg.sv
// ----------------------------------------------------------------------------
// asrl_pkg
// Shared types and constants of the address-to-symbol range lookup core.
// ----------------------------------------------------------------------------
package asrl_pkg;

   // default table depth
   localparam int DEFAULT_MAX_SYMBOLS = 256;

   // symbol type nibble that marks a function
   localparam logic [3:0] KIND_FUNCTION = 4'h2;

   // request action codes
   localparam logic ACT_WRITE  = 1'b0;
   localparam logic ACT_LOOKUP = 1'b1;

   // register indexes
   localparam logic CSR_SYMBOL_COUNT = 1'b0;
   localparam logic CSR_STRING_BASE  = 1'b1;

   // one stored table entry; stop is the wrapped end start+size
   typedef struct packed {
      logic        is_function;
      logic [31:0] start;
      logic [31:0] stop;
      logic [31:0] name_offset;
   } entry_type;

endpackage

>>> hdl/asrl_table.sv
// ----------------------------------------------------------------------------
// asrl_table
// Symbol table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module asrl_table #(
   parameter int MAX_SYMBOLS = asrl_pkg::DEFAULT_MAX_SYMBOLS,
   parameter int IDX_W       = 8
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  logic [31:0]         wr_start,
   input  logic [31:0]         wr_size,
   input  logic [3:0]          wr_kind,
   input  logic [31:0]         wr_name_offset,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_addr,
   output asrl_pkg::entry_type rd_data
);
   import asrl_pkg::*;

   entry_type mem [MAX_SYMBOLS];
   entry_type wr_entry;
   entry_type rd_data_ff;

   // range end is folded in on the way in, so a lookup only compares
   always_comb begin
      wr_entry.is_function = (wr_kind == KIND_FUNCTION);
      wr_entry.start       = wr_start;
      wr_entry.stop        = wr_start + wr_size;
      wr_entry.name_offset = wr_name_offset;
   end

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/address_symbol_range_lookup_core.sv
// ----------------------------------------------------------------------------
// address_symbol_range_lookup_core
// Resolves a code address to the name address of the covering function symbol.
// ----------------------------------------------------------------------------
// A write request with an index below MAX_SYMBOLS stores one symbol entry and gives no response.
// A lookup request scans entries 0 to min(symbol_count, MAX_SYMBOLS)-1 in
// order, reading one entry per cycle from the table memory, and stops at the
// first function entry with start <= address < start+size (32-bit wrapped
// end). A lookup keeps the block busy while it scans, which ends at the
// first match, after the last entry on a miss, or at once for an empty table.
// The response register frees the input side: a new request is taken
// as soon as the block is idle, and a finished lookup waits only while an
// earlier response has not been taken. Table entries read before written
// give undefined results.
`include "address_symbol_range_lookup_core_assert.svh"

module address_symbol_range_lookup_core #(
   parameter int MAX_SYMBOLS = asrl_pkg::DEFAULT_MAX_SYMBOLS
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [7:0]  req_entry_index,
   input  logic [31:0] req_entry_start,
   input  logic [31:0] req_entry_size,
   input  logic [3:0]  req_entry_kind,
   input  logic [31:0] req_entry_name_offset,
   input  logic [31:0] req_query_address,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic [7:0]  rsp_match_index,
   output logic [31:0] rsp_name_address,
   // register write port
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [31:0] csr_write_data
);
   import asrl_pkg::*;

   localparam int IDX_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
   localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [31:0]      addr_ff, addr_in;
   logic [CNT_W-1:0] limit_ff, limit_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [31:0]      hit_off_ff, hit_off_in;

   logic [8:0]       symbol_count_ff;
   logic [31:0]      string_base_ff;

   logic             rsp_valid_ff;
   logic             rsp_found_ff;
   logic [7:0]       rsp_index_ff;
   logic [31:0]      rsp_name_ff;

   logic             req_accept;
   logic             wr_en;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   entry_type        rd_data;
   logic [CNT_W-1:0] limit_now;
   logic [CNT_W:0]   next_cnt;
   logic             entry_hit;
   logic             rsp_free;

   // symbol table
   asrl_table #(
      .MAX_SYMBOLS (MAX_SYMBOLS),
      .IDX_W       (IDX_W)
   ) u_table (
      .clock          (clock),
      .wr_en          (wr_en),
      .wr_addr        (IDX_W'(req_entry_index)),
      .wr_start       (req_entry_start),
      .wr_size        (req_entry_size),
      .wr_kind        (req_entry_kind),
      .wr_name_offset (req_entry_name_offset),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data)
   );

   // handshake and write decode
   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign wr_en      = req_accept && (req_action == ACT_WRITE) &&
                       (32'(req_entry_index) < 32'(MAX_SYMBOLS));
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   // scan bound, clipped to the table depth
   always_comb begin
      if (32'(symbol_count_ff) > 32'(MAX_SYMBOLS)) begin
         limit_now = CNT_W'(MAX_SYMBOLS);
      end else begin
         limit_now = CNT_W'(symbol_count_ff);
      end
   end

   // range test on the entry read last cycle
   assign next_cnt  = (CNT_W+1)'(cmp_idx_ff) + (CNT_W+1)'(1);
   assign entry_hit = rd_data.is_function && (rd_data.start <= addr_ff) &&
                      (addr_ff < rd_data.stop);

   // sequencer
   always_comb begin
      state_in   = state_ff;
      addr_in    = addr_ff;
      limit_in   = limit_ff;
      cmp_idx_in = cmp_idx_ff;
      hit_in     = hit_ff;
      hit_idx_in = hit_idx_ff;
      hit_off_in = hit_off_ff;
      rd_en      = 1'b0;
      rd_addr    = IDX_W'(next_cnt);
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_action == ACT_LOOKUP)) begin
               addr_in    = req_query_address;
               limit_in   = limit_now;
               cmp_idx_in = '0;
               hit_in     = 1'b0;
               if (limit_now == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (entry_hit) begin
               hit_in     = 1'b1;
               hit_idx_in = cmp_idx_ff;
               hit_off_in = rd_data.name_offset;
               state_in   = ST_FINISH;
            end else if (next_cnt == {1'b0, limit_ff}) begin
               state_in = ST_FINISH;
            end else begin
               cmp_idx_in = IDX_W'(next_cnt);
               rd_en      = 1'b1;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // lookup working registers
   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      limit_ff   <= limit_in;
      cmp_idx_ff <= cmp_idx_in;
      hit_ff     <= hit_in;
      hit_idx_ff <= hit_idx_in;
      hit_off_ff <= hit_off_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         symbol_count_ff <= '0;
         string_base_ff  <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SYMBOL_COUNT: symbol_count_ff <= csr_write_data[8:0];
            CSR_STRING_BASE:  string_base_ff  <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_FINISH) && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_FINISH) && rsp_free) begin
         rsp_found_ff <= hit_ff;
         rsp_index_ff <= hit_ff ? 8'(hit_idx_ff) : 8'd0;
         rsp_name_ff  <= hit_ff ? (string_base_ff + hit_off_ff) : 32'd0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_match_index  = rsp_index_ff;
   assign rsp_name_address = rsp_name_ff;

   // checks
   `ASRL_ASSERT_SAME(a_scan_in_bound, state_ff == ST_SCAN, (CNT_W+1)'(cmp_idx_ff) < (CNT_W+1)'(limit_ff))
   `ASRL_ASSERT_SAME(a_miss_zero, rsp_valid_ff && !rsp_found_ff, (rsp_index_ff == 8'd0) && (rsp_name_ff == 32'd0))
   `ASRL_ASSERT_NEXT(a_lookup_busy, req_accept && (req_action == ACT_LOOKUP), state_ff != ST_IDLE)
   `ASRL_ASSERT_NEXT(a_write_idle, req_accept && (req_action == ACT_WRITE), state_ff == ST_IDLE)

endmodule
